// ----- rtl/core/imu_sample_gap_fill_interp_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the IMU gap fill resampler
// Concurrent checks on clk, disabled while rst is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef IMU_SAMPLE_GAP_FILL_INTERP_TOP_ASSERT_SVH
`define IMU_SAMPLE_GAP_FILL_INTERP_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// a holds now -> b holds in the same cycle
`define IGF_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a holds now -> b holds in the next cycle
`define IGF_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`else

`define IGF_ASSERT_NOW(lbl, a, b)
`define IGF_ASSERT_NEXT(lbl, a, b)

`endif

`endif

// ----- rtl/core/igf_pkg.sv -----
// ----------------------------------------------------------------------------
// igf_pkg
// Shared types and constants of the IMU gap fill resampler.
// ----------------------------------------------------------------------------
package igf_pkg;

  localparam int TOTAL_W   = 50;  // signed prev*gap + diff*num
  localparam int QUO_W     = 17;  // quotient bits (|value| <= 32768)
  localparam int MUL_STEPS = 17;  // one multiplier bit per cycle, 17-bit diff
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = 5;

  localparam logic [15:0] PERIOD_RESET  = 16'd1000;
  localparam logic [15:0] MIN_GAP_RESET = 16'd500;

  localparam logic REG_PERIOD  = 1'b0;
  localparam logic REG_MIN_GAP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAP,
    ST_MUL,
    ST_ADD,
    ST_DLOAD,
    ST_DIV,
    ST_EMIT,
    ST_CHECK,
    ST_REAL
  } state_t;

  typedef struct packed {
    logic mul_load;
    logic mul_step;
    logic mul_first;
    logic add_step;
    logic div_load;
    logic div_step;
  } lane_ctrl_t;

endpackage

// ----- rtl/core/igf_lane.sv -----
// ----------------------------------------------------------------------------
// igf_lane
// One axis: bit-serial multiply for prev*gap and diff*period, running sum
// per fill step, bit-serial restoring divide by the gap.
// ----------------------------------------------------------------------------
module igf_lane (
  input  logic                clk,
  input  igf_pkg::lane_ctrl_t ctrl,
  input  logic signed [15:0]  prev,
  input  logic signed [15:0]  now,
  input  logic [31:0]         gap,
  input  logic [15:0]         per,
  output logic signed [15:0]  value
);

  localparam int TW = igf_pkg::TOTAL_W;
  localparam int QW = igf_pkg::QUO_W;

  logic [16:0]   pmul;    // prev, sign extended, MSB first
  logic [16:0]   dmul;    // now - prev, MSB first
  logic [TW-1:0] total;
  logic [TW-1:0] step;
  logic [31:0]   rem;
  logic [QW-1:0] lo;      // dividend bits in, quotient bits out
  logic          neg;

  logic [TW-1:0] gap_ext;
  logic [TW-1:0] per_ext;
  logic [TW-1:0] mag;
  logic [32:0]   trial;
  logic          ge;
  logic [32:0]   diff;
  logic [QW-1:0] q_neg;

  assign gap_ext = TW'(gap);
  assign per_ext = TW'(per);
  assign mag     = total[TW-1] ? (TW'(0) - total) : total;
  assign trial   = {rem, lo[QW-1]};
  assign ge      = trial >= {1'b0, gap};
  assign diff    = trial - {1'b0, gap};
  assign q_neg   = QW'(0) - lo;
  assign value   = neg ? q_neg[15:0] : lo[15:0];

  always_ff @(posedge clk) begin
    if (ctrl.mul_load) begin
      pmul  <= {prev[15], prev};
      dmul  <= {now[15], now} - {prev[15], prev};
      total <= '0;
      step  <= '0;
    end else if (ctrl.mul_step) begin
      // Horner from the MSB; the sign bit carries negative weight
      if (ctrl.mul_first) begin
        total <= pmul[16] ? (TW'(0) - gap_ext) : '0;
        step  <= dmul[16] ? (TW'(0) - per_ext) : '0;
      end else begin
        total <= (total << 1) + (pmul[16] ? gap_ext : '0);
        step  <= (step << 1) + (dmul[16] ? per_ext : '0);
      end
      pmul <= {pmul[15:0], 1'b0};
      dmul <= {dmul[15:0], 1'b0};
    end else if (ctrl.add_step) begin
      total <= total + step;
    end else if (ctrl.div_load) begin
      neg <= total[TW-1];
      rem <= mag[TW-2:QW];
      lo  <= mag[QW-1:0];
    end else if (ctrl.div_step) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      lo  <= {lo[QW-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/imu_sample_gap_fill_interp_top.sv -----
// ----------------------------------------------------------------------------
// imu_sample_gap_fill_interp_top - IMU sample gap fill resampler
// Pass-through sample: accepted in IDLE, then GAP and REAL; REAL loads the
// result word and returns to IDLE, where the next sample can be taken.
// Filled gap: n synthesized words (n <= MAX_FILL) before the real word; MUL runs
// once per sample, then each fill word passes ADD, DLOAD, the bit-serial divide
// (DIV), EMIT and CHECK. One sample at a time; a new sample is taken once the
// real word is in the output register. Sync reset clears state and config.
// ----------------------------------------------------------------------------
//
// Flow per sample:
//   IDLE  accept; first sample after reset is only stored. Gap is latched.
//   GAP   short gap drops the sample; no room for a fill goes straight to REAL.
//   MUL   each lane forms prev*gap and (now-prev)*period serially.
//   ADD   total += (now-prev)*period, i.e. total = prev*gap + diff*k*period.
//   DLOAD sign/magnitude split of total into the divider.
//   DIV   restoring divide by gap, one quotient bit a cycle.
//   EMIT  synthesized word out at prev_stamp + k*period; k, num advance.
//   CHECK another fill while (k+1)*period <= gap and k <= MAX_FILL.
//   REAL  real word out with run_end, sample becomes the stored one.
//
`include "imu_sample_gap_fill_interp_top_assert.svh"

module imu_sample_gap_fill_interp_top #(
  parameter int MAX_FILL = 31
) (
  input  logic               clk,
  input  logic               rst,

  // configuration
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,

  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [31:0]        stamp,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,

  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        out_stamp,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic               synthesized,
  output logic               run_end
);

  localparam int KW    = $clog2(MAX_FILL + 2);  // k runs 1..MAX_FILL+1
  localparam int NUM_W = 16 + KW;               // k*period
  localparam int CMP_W = 33;
  localparam int CW    = igf_pkg::CNT_W;

  igf_pkg::state_t     state, state_next;
  logic [CW-1:0]       cnt, cnt_next;
  igf_pkg::lane_ctrl_t ctrl;

  // config
  logic [15:0] sample_period;
  logic [15:0] min_gap;

  // stored sample
  logic               have_prev;
  logic [31:0]        prev_stamp;
  logic signed [15:0] prev_x, prev_y, prev_z;

  // sample under work
  logic [31:0]        cur_stamp;
  logic signed [15:0] cur_x, cur_y, cur_z;
  logic [31:0]        gap;
  logic [KW-1:0]      k_cnt;
  logic [NUM_W-1:0]   num;

  logic signed [15:0] val_x, val_y, val_z;

  logic accept, out_free, fill_ok, is_drop;
  logic store_first, ld_cur, emit_syn, emit_real;

  assign sample_stall = (state != igf_pkg::ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;
  assign is_drop      = gap < 32'(min_gap);

  // next fill k is legal while (k+1)*period fits in the gap
  assign fill_ok = (sample_period != 16'd0)
                && ((CMP_W'(num) + CMP_W'(sample_period)) <= CMP_W'(gap))
                && (k_cnt <= KW'(MAX_FILL));

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= igf_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ctrl        = '0;
    store_first = 1'b0;
    ld_cur      = 1'b0;
    emit_syn    = 1'b0;
    emit_real   = 1'b0;
    case (state)
      igf_pkg::ST_IDLE: begin
        if (accept) begin
          if (!have_prev) begin
            store_first = 1'b1;
          end else begin
            ld_cur     = 1'b1;
            state_next = igf_pkg::ST_GAP;
          end
        end
      end
      igf_pkg::ST_GAP: begin
        if (is_drop) begin
          state_next = igf_pkg::ST_IDLE;
        end else if (fill_ok) begin
          ctrl.mul_load = 1'b1;
          cnt_next      = '0;
          state_next    = igf_pkg::ST_MUL;
        end else begin
          state_next = igf_pkg::ST_REAL;
        end
      end
      igf_pkg::ST_MUL: begin
        ctrl.mul_step  = 1'b1;
        ctrl.mul_first = (cnt == '0);
        if (cnt == CW'(igf_pkg::MUL_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = igf_pkg::ST_ADD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      igf_pkg::ST_ADD: begin
        ctrl.add_step = 1'b1;
        state_next    = igf_pkg::ST_DLOAD;
      end
      igf_pkg::ST_DLOAD: begin
        ctrl.div_load = 1'b1;
        cnt_next      = '0;
        state_next    = igf_pkg::ST_DIV;
      end
      igf_pkg::ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (cnt == CW'(igf_pkg::DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = igf_pkg::ST_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      igf_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_syn   = 1'b1;
          state_next = igf_pkg::ST_CHECK;
        end
      end
      igf_pkg::ST_CHECK: begin
        state_next = fill_ok ? igf_pkg::ST_ADD : igf_pkg::ST_REAL;
      end
      igf_pkg::ST_REAL: begin
        if (out_free) begin
          emit_real  = 1'b1;
          state_next = igf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = igf_pkg::ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------ config regs
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= igf_pkg::PERIOD_RESET;
      min_gap       <= igf_pkg::MIN_GAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        igf_pkg::REG_PERIOD:  sample_period <= cfg_data;
        igf_pkg::REG_MIN_GAP: min_gap       <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ stored sample
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      prev_stamp <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      prev_z     <= '0;
    end else if (store_first) begin
      have_prev  <= 1'b1;
      prev_stamp <= stamp;
      prev_x     <= accel_x;
      prev_y     <= accel_y;
      prev_z     <= accel_z;
    end else if (emit_real) begin
      prev_stamp <= cur_stamp;
      prev_x     <= cur_x;
      prev_y     <= cur_y;
      prev_z     <= cur_z;
    end
  end

  // ------------------------------------------------------------ working regs
  always_ff @(posedge clk) begin
    if (ld_cur) begin
      cur_stamp <= stamp;
      cur_x     <= accel_x;
      cur_y     <= accel_y;
      cur_z     <= accel_z;
      gap       <= stamp - prev_stamp;  // wraps mod 2^32
      k_cnt     <= KW'(1);
      num       <= NUM_W'(sample_period);
    end else if (emit_syn) begin
      k_cnt <= k_cnt + 1'b1;
      num   <= num + NUM_W'(sample_period);
    end
  end

  // ------------------------------------------------------------ axis lanes
  igf_lane u_lane_x (
    .clk   (clk),
    .ctrl  (ctrl),
    .prev  (prev_x),
    .now   (cur_x),
    .gap   (gap),
    .per   (sample_period),
    .value (val_x)
  );

  igf_lane u_lane_y (
    .clk   (clk),
    .ctrl  (ctrl),
    .prev  (prev_y),
    .now   (cur_y),
    .gap   (gap),
    .per   (sample_period),
    .value (val_y)
  );

  igf_lane u_lane_z (
    .clk   (clk),
    .ctrl  (ctrl),
    .prev  (prev_z),
    .now   (cur_z),
    .gap   (gap),
    .per   (sample_period),
    .value (val_z)
  );

  // ------------------------------------------------------------ output word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_syn || emit_real) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_syn) begin
      out_stamp   <= prev_stamp + 32'(num);
      out_x       <= val_x;
      out_y       <= val_y;
      out_z       <= val_z;
      synthesized <= 1'b1;
      run_end     <= 1'b0;
    end else if (emit_real) begin
      out_stamp   <= cur_stamp;
      out_x       <= cur_x;
      out_y       <= cur_y;
      out_z       <= cur_z;
      synthesized <= 1'b0;
      run_end     <= 1'b1;
    end
  end

  // ------------------------------------------------------------ checks
  // loading the real word always ends the run and frees the input
  `IGF_ASSERT_NEXT(a_real_ends_run, (state == igf_pkg::ST_REAL) && out_free, (state == igf_pkg::ST_IDLE) && result_valid && run_end)
  // fill index never runs past the clamp
  `IGF_ASSERT_NOW(a_fill_bound, result_valid && synthesized, k_cnt <= KW'(MAX_FILL + 1))
  // a new sample is never taken while a fill word is still pending
  `IGF_ASSERT_NOW(a_no_accept_mid_run, accept, !(result_valid && synthesized))

endmodule

// ----- verif/tb_imu_sample_gap_fill_interp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU gap fill resampler testbench
// Drives timestamped accelerometer samples with random idles and stalls,
// predicts every emitted word (fill and real) and compares them in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [31:0]        stamp;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [15:0] z;
  logic               synth;
  logic               last;
} fill_word_t;

class fill_scoreboard #(int FILL_CAP = 31);
  logic [15:0]        period;
  logic [15:0]        min_gap;
  bit                 have_prev;
  logic [31:0]        prev_stamp;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;
  logic signed [15:0] prev_z;
  fill_word_t         pending[$];
  int                 errors;
  int                 shown;

  function new();
    period     = igf_pkg::PERIOD_RESET;
    min_gap    = igf_pkg::MIN_GAP_RESET;
    have_prev  = 1'b0;
    prev_stamp = '0;
    prev_x     = '0;
    prev_y     = '0;
    prev_z     = '0;
    errors     = 0;
    shown      = 0;
  endfunction

  function void set_reg(logic idx, logic [15:0] val);
    if (idx == igf_pkg::REG_PERIOD) period = val;
    else min_gap = val;
  endfunction

  function int outstanding();
    return pending.size();
  endfunction

  // prev + (now - prev) * num / gap, exact, truncated toward zero
  function automatic logic signed [15:0] blend_axis(logic signed [15:0] a,
                                                    logic signed [15:0] b,
                                                    longint num, longint gap);
    longint total;
    total = longint'(a) * gap + (longint'(b) - longint'(a)) * num;
    return 16'(total / gap);
  endfunction

  function void note_sample(logic [31:0] st, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
    logic [31:0] gap;
    longint      g;
    longint      p;
    longint      n;
    longint      num;
    fill_word_t  w;
    if (!have_prev) begin
      have_prev  = 1'b1;
      prev_stamp = st;
      prev_x     = x;
      prev_y     = y;
      prev_z     = z;
      return;
    end
    gap = st - prev_stamp;
    if (gap < {16'b0, min_gap}) return;
    g = gap;
    p = period;
    if (p != 0 && g >= 2 * p) begin
      n = g / p - 1;
      if (n > FILL_CAP) n = FILL_CAP;
      for (longint k = 1; k <= n; k++) begin
        num     = k * p;
        w.stamp = prev_stamp + 32'(num);
        w.x     = blend_axis(prev_x, x, num, g);
        w.y     = blend_axis(prev_y, y, num, g);
        w.z     = blend_axis(prev_z, z, num, g);
        w.synth = 1'b1;
        w.last  = 1'b0;
        pending.insert(pending.size(), w);
      end
    end
    w.stamp = st;
    w.x     = x;
    w.y     = y;
    w.z     = z;
    w.synth = 1'b0;
    w.last  = 1'b1;
    pending.insert(pending.size(), w);
    prev_stamp = st;
    prev_x     = x;
    prev_y     = y;
    prev_z     = z;
  endfunction

  function void check_word(fill_word_t got);
    fill_word_t want;
    if (pending.size() == 0) begin
      errors++;
      if (shown++ < 100)
        $display("%0t: unexpected word stamp=%h x=%0d y=%0d z=%0d synth=%b last=%b",
                 $time, got.stamp, got.x, got.y, got.z, got.synth, got.last);
      return;
    end
    want = pending[0];
    pending.delete(0);
    if (got.stamp !== want.stamp || got.x !== want.x || got.y !== want.y ||
        got.z !== want.z || got.synth !== want.synth || got.last !== want.last) begin
      errors++;
      if (shown++ < 100)
        $display("%0t: mismatch expected stamp=%h x=%0d y=%0d z=%0d synth=%b last=%b",
                 $time, want.stamp, want.x, want.y, want.z, want.synth, want.last,
                 " actual stamp=%h x=%0d y=%0d z=%0d synth=%b last=%b",
                 got.stamp, got.x, got.y, got.z, got.synth, got.last);
    end
  endfunction
endclass

module tb_imu_sample_gap_fill_interp_top;

  localparam int FILL_CAP      = 31;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 65;
  localparam int HOLD_CYCLES   = 300;
  // drops and first samples leave no word behind; give the FSM time to
  // fall back to idle before touching config
  localparam int SETTLE_CYCLES = 64;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               sample_valid;
  logic               sample_stall;
  logic [31:0]        stamp;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic               result_valid;
  logic               result_stall;
  logic [31:0]        out_stamp;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               synthesized;
  logic               run_end;

  // calm: no idling on either side; hold_seq: bump to start a long receiver
  // hold-off (counted in the sink process)
  logic               calm;
  int                 hold_seq;

  fill_scoreboard #(FILL_CAP) sb;

  imu_sample_gap_fill_interp_top #(.MAX_FILL(FILL_CAP)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stamp        (stamp),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_stamp    (out_stamp),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .synthesized  (synthesized),
    .run_end      (run_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog. Slowest legal run is well under 3 ms; this is several times that.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: check every accepted word, then pick next cycle's stall.
  // Values are sampled right after the edge, i.e. as they were at the edge.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int         hold_left;
    int         hold_seen;
    fill_word_t got;
    hold_left = 0;
    hold_seen = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        got.stamp = out_stamp;
        got.x     = out_x;
        got.y     = out_y;
        got.z     = out_z;
        got.synth = synthesized;
        got.last  = run_end;
        sb.check_word(got);
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side tasks. Every task starts right after an edge; each leaves at
  // most one pending assignment per signal in the current step.
  // ---------------------------------------------------------------------------

  // offer one word, wait for the accepting edge, then maybe idle a while
  task automatic offer_sample(logic [31:0] st, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [15:0] z);
    sample_valid <= 1'b1;
    stamp        <= st;
    accel_x      <= x;
    accel_y      <= y;
    accel_z      <= z;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(st, x, y, z);
    if (!calm) begin
      while ($urandom_range(99) < 23) begin
        sample_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // stamp relative to the stored sample (drops do not move it)
  task automatic offer_gap(logic [31:0] gap, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    offer_sample(sb.prev_stamp + gap, x, y, z);
  endtask

  // sender goes quiet until every predicted word is out, plus slack
  task automatic wait_settled();
    sample_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // mostly random counts, with a fair share of full-scale values
  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // gap mix: drops, pass-through, fills (short and clamped), wild jumps
  function automatic logic [31:0] pick_gap(logic [15:0] per, logic [15:0] mg);
    longint p;
    longint lo;
    longint hi;
    longint k;
    int     sel;
    p   = (per == 0) ? 1000 : per;
    sel = $urandom_range(99);
    if (sel < 10 && mg != 0) return $urandom_range(mg - 1);
    if (sel < 40) begin
      lo = mg;
      hi = 2 * p - 1;
      if (hi < lo) hi = lo;
      return $urandom_range(32'(hi), 32'(lo));
    end
    if (sel < 88) begin
      k = ($urandom_range(3) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 2);
      return 32'(k * p + $urandom_range(32'(p - 1)));
    end
    return $urandom;   // huge forward or backward jump
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] per;
    logic [15:0] mg;
    sb = new();
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= igf_pkg::REG_PERIOD;
    cfg_data     <= '0;
    sample_valid <= 1'b0;
    stamp        <= '0;
    accel_x      <= '0;
    accel_y      <= '0;
    accel_z      <= '0;
    calm         <= 1'b0;
    hold_seq     <= 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, reset config: period 1000, min gap 500 ---
    offer_sample(32'd100, 16'sd0, 16'sd0, 16'sd0);          // first: stored only
    offer_gap(32'd1000, 16'sh8000, 16'sh7FFF, 16'sd0);      // pass-through
    offer_gap(32'd499, 16'sd1, 16'sd2, 16'sd3);             // just under min: drop
    offer_gap(32'd500, -16'sd32768, 16'sd32767, 16'sd0);    // exactly min: pass
    offer_gap(32'd5000, 16'sh7FFF, 16'sh8000, -16'sd1);     // four fills, full swing
    offer_gap(32'd2000, -16'sd1, 16'sd1, 16'sh8000);        // exactly two periods
    offer_gap(32'd1_000_000, 16'sd12345, -16'sd12345, 16'sh7FFF);  // clamped fill
    offer_sample(32'd5, 16'sh8000, 16'sh8000, 16'sh8000);   // backward stamp
    offer_sample(32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    offer_gap(32'd1000, -16'sd7, 16'sd7, 16'sd0);           // wraps through zero

    // zero period: nothing is ever synthesized
    wait_settled();
    write_reg(igf_pkg::REG_PERIOD, 16'd0);
    write_reg(igf_pkg::REG_MIN_GAP, 16'd0);
    offer_gap(32'd0, 16'sd100, -16'sd100, 16'sd5);          // zero gap passes
    offer_gap(32'd50000, -16'sd300, 16'sd300, 16'sd9);

    // widest period and min gap
    wait_settled();
    write_reg(igf_pkg::REG_PERIOD, 16'hFFFF);
    write_reg(igf_pkg::REG_MIN_GAP, 16'hFFFF);
    offer_gap(32'd65534, 16'sd1, 16'sd1, 16'sd1);           // drop
    offer_gap(32'd65535, 16'sh8000, 16'sd0, 16'sh7FFF);     // pass
    offer_gap(32'd131070, 16'sh7FFF, 16'sd0, 16'sh8000);    // one fill
    offer_gap(32'h8000_0000, -16'sd2, 16'sd3, -16'sd4);     // clamped

    // unit period: every gap over 32 clamps
    wait_settled();
    write_reg(igf_pkg::REG_PERIOD, 16'd1);
    write_reg(igf_pkg::REG_MIN_GAP, 16'd0);
    offer_gap(32'd33, 16'sh8000, 16'sh7FFF, 16'sd0);
    offer_gap(32'd5, 16'sd10, -16'sd10, 16'sd0);
    offer_gap(32'd1, 16'sd0, 16'sd0, 16'sd0);

    // --- random phases, one config each ---
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_settled();   // also the "sender waits for every word" pause
      case (ph)
        0: begin per = 16'd1000; mg = 16'd500; end
        1: begin per = 16'($urandom_range(50, 2)); mg = 16'($urandom_range(per)); end
        2: begin per = 16'hFFFF; mg = 16'd0; end
        3: begin per = 16'd1; mg = 16'd0; end
        4: begin per = 16'($urandom_range(65535, 1)); mg = 16'($urandom_range(65535)); end
        default: begin
          per = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(5000, 1));
          mg  = 16'($urandom_range(per));
        end
      endcase
      write_reg(igf_pkg::REG_PERIOD, per);
      write_reg(igf_pkg::REG_MIN_GAP, mg);
      // first phase runs with no idling at all; second opens with a long
      // receiver hold-off while the sender keeps pushing
      calm <= (ph == 0);
      if (ph == 1) hold_seq <= hold_seq + 1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        offer_gap(pick_gap(per, mg), pick_axis(), pick_axis(), pick_axis());
    end

    wait_settled();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
